// File: src/rwt_pkg.sv
package rwt_pkg;

  localparam int unsigned CFG_W   = 64;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TICK_W  = 8;
  localparam int unsigned MAX_LEN = 8;

  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_BEGIN = 2'd2;

  localparam logic [1:0] ST_WAIT    = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;
  localparam logic [1:0] ST_ANSWER  = 2'd3;

  localparam logic [2:0] REG_ANS_PAT = 3'd0;
  localparam logic [2:0] REG_ANS_LEN = 3'd1;
  localparam logic [2:0] REG_ERR_PAT = 3'd2;
  localparam logic [2:0] REG_ERR_LEN = 3'd3;
  localparam logic [2:0] REG_TIMEOUT = 3'd4;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// File: src/rwt_cell.sv
module rwt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rwt_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          byte_i,
  input  logic [7:0]          ans_want_i,
  input  logic [7:0]          err_want_i,
  output logic [7:0]          byte_o,
  output logic                ans_eq_o,
  output logic                err_eq_o
);
  import rwt_pkg::*;

  logic [BYTE_W-1:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = '0;
    end else if (ctrl_i.shift) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  // compare against the window as it stands after this beat
  assign ans_eq_o = (byte_d == ans_want_i);
  assign err_eq_o = (byte_d == err_want_i);
  assign byte_o   = byte_q;

endmodule

// File: src/response_watch_with_timeout.sv
// a poll tick beat gives its registered status beat in the cycle after acceptance
// throughput: one beat per cycle when not held off; each byte beat shifts the cell row by one cell
// a tick beat is held off only while the previous status beat is stalled at the output
// reset: async active low, clears window, counters, flags and config to defaults
// no clearing pass after reset, the block takes beats in the first cycle
module response_watch_with_timeout #(
  parameter int unsigned PATTERN_BYTES = 8,
  parameter int unsigned BUFFER_DEPTH  = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o
);
  import rwt_pkg::*;

  localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned CMP_CELLS = (PATTERN_BYTES < MAX_LEN) ? PATTERN_BYTES : MAX_LEN;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CMP_CELLS);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_DEPTH);

  // config registers
  logic [CFG_W-1:0]  ans_pat_q, err_pat_q;
  logic [LEN_W-1:0]  ans_len_q, err_len_q;
  logic [TICK_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ans_pat_q <= '0;
      ans_len_q <= LEN_W'(1);
      err_pat_q <= '0;
      err_len_q <= '0;
      limit_q   <= TICK_W'(33);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ANS_PAT: ans_pat_q <= cfg_wdata_i;
        REG_ANS_LEN: ans_len_q <= cfg_wdata_i[LEN_W-1:0];
        REG_ERR_PAT: err_pat_q <= cfg_wdata_i;
        REG_ERR_LEN: err_len_q <= cfg_wdata_i[LEN_W-1:0];
        REG_TIMEOUT: limit_q   <= cfg_wdata_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LEN_W-1:0] ans_len, err_len;
  assign ans_len = (ans_len_q > LEN_CAP) ? LEN_CAP : ans_len_q;
  assign err_len = (err_len_q > LEN_CAP) ? LEN_CAP : err_len_q;

  // handshake
  logic accept, acc_byte, acc_tick, acc_begin;
  assign in_stall_o = out_valid_o && out_stall_i && (mode_i == MODE_TICK);
  assign accept     = in_valid_i && !in_stall_o;
  assign acc_tick   = accept && (mode_i == MODE_TICK);
  assign acc_begin  = accept && (mode_i == MODE_BEGIN);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  assign acc_byte = accept && (mode_i == MODE_BYTE) && (cnt_q != CNT_FULL);

  cell_ctrl_t ctrl;
  assign ctrl.shift = acc_byte;
  assign ctrl.clear = acc_begin;

  // cell row, newest byte in cell 0
  logic [PATTERN_BYTES-1:0][BYTE_W-1:0] win;
  logic [PATTERN_BYTES-1:0]             ans_eq, err_eq, ans_use, err_use;

  for (genvar k = 0; k < PATTERN_BYTES; k++) begin : g_cell
    logic [BYTE_W-1:0] ans_want, err_want, from_prev;

    if (k == 0) begin : g_head
      assign from_prev = rx_byte_i;
    end else begin : g_link
      assign from_prev = win[k-1];
    end

    if (k < CMP_CELLS) begin : g_cmp
      localparam logic [LEN_W-1:0] KL = LEN_W'(k);
      logic [2:0] ans_idx, err_idx;
      // cell k holds pattern byte len-1-k
      assign ans_idx  = 3'(ans_len - KL - LEN_W'(1));
      assign err_idx  = 3'(err_len - KL - LEN_W'(1));
      assign ans_want = ans_pat_q[BYTE_W*ans_idx +: BYTE_W];
      assign err_want = err_pat_q[BYTE_W*err_idx +: BYTE_W];
      assign ans_use[k] = (KL < ans_len);
      assign err_use[k] = (KL < err_len);
    end else begin : g_nocmp
      assign ans_want   = '0;
      assign err_want   = '0;
      assign ans_use[k] = 1'b0;
      assign err_use[k] = 1'b0;
    end

    rwt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .byte_i     (from_prev),
      .ans_want_i (ans_want),
      .err_want_i (err_want),
      .byte_o     (win[k]),
      .ans_eq_o   (ans_eq[k]),
      .err_eq_o   (err_eq[k])
    );
  end

  logic [CNT_W-1:0] cnt_inc;
  logic             ans_hit, err_hit;
  assign cnt_inc = cnt_q + CNT_W'(1);
  assign ans_hit = (ans_len != '0) && (cnt_inc >= CNT_W'(ans_len)) && (&(ans_eq | ~ans_use));
  assign err_hit = (err_len != '0) && (cnt_inc >= CNT_W'(err_len)) && (&(err_eq | ~err_use));

  // wait state
  logic              ans_seen_q, ans_seen_d, err_seen_q, err_seen_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [1:0]        final_q, final_d;

  always_comb begin
    cnt_d      = cnt_q;
    ans_seen_d = ans_seen_q;
    err_seen_d = err_seen_q;
    tick_d     = tick_q;
    final_d    = final_q;
    if (acc_begin) begin
      cnt_d      = '0;
      ans_seen_d = 1'b0;
      err_seen_d = 1'b0;
      tick_d     = '0;
      final_d    = ST_WAIT;
    end else if (acc_byte) begin
      cnt_d = cnt_inc;
      if (ans_hit) ans_seen_d = 1'b1;
      if (err_hit) err_seen_d = 1'b1;
    end else if (acc_tick && (final_q == ST_WAIT)) begin
      priority if (tick_q > limit_q) begin
        final_d = ST_TIMEOUT;
      end else if ((err_len_q != '0) && err_seen_q) begin
        final_d = ST_ERROR;
      end else if (ans_seen_q) begin
        final_d = ST_ANSWER;
      end else if (tick_q != '1) begin
        tick_d = tick_q + TICK_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      ans_seen_q <= 1'b0;
      err_seen_q <= 1'b0;
      tick_q     <= '0;
      final_q    <= ST_WAIT;
    end else begin
      cnt_q      <= cnt_d;
      ans_seen_q <= ans_seen_d;
      err_seen_q <= err_seen_d;
      tick_q     <= tick_d;
      final_q    <= final_d;
    end
  end

  // output register
  logic       out_valid_q;
  logic [1:0] status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc_tick) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_tick) begin
      status_q <= final_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

endmodule

// File: src/rwt_checker.sv
module rwt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] mode_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o
);
  import rwt_pkg::*;

  logic tick_acc, begin_acc;
  assign tick_acc  = in_valid_i && !in_stall_o && (mode_i == MODE_TICK);
  assign begin_acc = in_valid_i && !in_stall_o && (mode_i == MODE_BEGIN);

  // every accepted tick produces a status beat next cycle
  a_tick_gives_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> out_valid_o)
    else $error("tick beat without status beat");

  // input is held off only by a stalled status beat
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without pending status");

  // first tick right after begin reports waiting
  a_begin_then_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (begin_acc ##1 tick_acc) |=> (status_o == ST_WAIT))
    else $error("non-waiting status right after begin");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o)))
    else $error("stalled status beat changed");

endmodule

bind response_watch_with_timeout rwt_checker u_rwt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .mode_i      (mode_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o)
);
